>>> design/profile_threshold_crossing_core_macros.svh
// assertion macros for the threshold crossing design
`ifndef PROFILE_THRESHOLD_CROSSING_CORE_MACROS_SVH
`define PROFILE_THRESHOLD_CROSSING_CORE_MACROS_SVH

// same-cycle implication, off while in reset
`define PTC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("ptc same-cycle check failed");

// next-cycle implication, off while in reset
`define PTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("ptc next-cycle check failed");

`endif

>>> design/ptc_pkg.sv
// shared types and constants for the threshold crossing design
`timescale 1ns / 1ps
`default_nettype none
package ptc_pkg;

	localparam int unsigned DEPTH_W = 1;
	localparam int unsigned STEPS = 33;
	localparam int unsigned CNT_W = 6;
	localparam logic [30:0] THR_RESET = 31'd177603;

	// one finished scan handed from front to back
	typedef struct packed {
		logic               found;
		logic signed [31:0] ly;
		logic signed [31:0] ry;
		logic signed [32:0] ld;
		logic signed [32:0] rd;
		logic        [30:0] thr;
	} ptc_job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_DONE
	} ptc_bk_state_t;

	localparam logic CFG_REF = 1'b0;
	localparam logic CFG_THR = 1'b1;

endpackage
`default_nettype wire

>>> design/profile_threshold_crossing_core.sv
// Threshold crossing finder over a (yield, chi2) scan with linear interpolation.
// The front takes one point per clock with no stall of its own: it keeps the running
// minimum and the first upward crossing pair after it. On the point marked last it
// puts the finished scan into a two-entry queue and starts a fresh scan at once.
// The back interpolates one scan at a time with a shift-and-subtract multiply-divide
// unit: it loads a scan, runs 33 steps and hands off, skipping the steps when no crossing
// was found or the pair is flat. Input ready drops only while the queue holds two
// scans, which happens when scans arrive faster than the back finishes them or when
// the output side holds off results. Registers are
// written through cfg_wr_en/cfg_index/cfg_wdata; index 0 is reference_chi2, index 1
// is delta_threshold (low 31 bits of cfg_wdata).
`timescale 1ns / 1ps
`default_nettype none
module profile_threshold_crossing_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // point_yield [31:0], point_chi2 [63:32]
	input  wire logic        s_axis_tlast,  // last_point
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // crossing_yield [31:0]
	output logic             m_axis_tuser,  // found [0]
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata
);
	import ptc_pkg::*;

	logic [31:0]        reference_chi2_q;
	logic [30:0]        delta_threshold_q;
	logic               in_fire;
	ptc_job_t           push_job;
	ptc_job_t           head;
	logic               push;
	logic               pop;
	logic               empty;
	logic               full;
	logic signed [31:0] out_yield;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reference_chi2_q <= '0;
			delta_threshold_q <= THR_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_REF: reference_chi2_q <= cfg_wdata;
				CFG_THR: delta_threshold_q <= cfg_wdata[30:0];
				default: reference_chi2_q <= reference_chi2_q;
			endcase
		end
	end

	assign s_axis_tready = !full;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	ptc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_fire         (in_fire),
		.point_yield     ($signed(s_axis_tdata[31:0])),
		.point_chi2      (s_axis_tdata[63:32]),
		.last_point      (s_axis_tlast),
		.reference_chi2  (reference_chi2_q),
		.delta_threshold (delta_threshold_q),
		.job             (push_job),
		.job_push        (push)
	);

	ptc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	ptc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_found (m_axis_tuser),
		.out_yield (out_yield)
	);

	assign m_axis_tdata = out_yield;

endmodule
`default_nettype wire

>>> design/ptc_front.sv
// front part: per-point minimum tracking and crossing pair capture
`timescale 1ns / 1ps
`default_nettype none
module ptc_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_fire,
	input  wire logic signed [31:0]    point_yield,
	input  wire logic        [31:0]    point_chi2,
	input  wire logic                  last_point,
	input  wire logic        [31:0]    reference_chi2,
	input  wire logic        [30:0]    delta_threshold,
	output ptc_pkg::ptc_job_t          job,
	output logic                       job_push
);
	import ptc_pkg::*;

	logic               have_prev_q;
	logic signed [31:0] prev_yield_q;
	logic        [31:0] prev_chi2_q;
	logic        [31:0] min_chi2_q;
	logic               have_cand_q;
	logic signed [31:0] cand_ly_q;
	logic signed [31:0] cand_ry_q;
	logic signed [32:0] cand_ld_q;
	logic signed [32:0] cand_rd_q;

	logic               lower;
	logic               capture;
	logic signed [32:0] ld;
	logic signed [32:0] rd;
	logic signed [32:0] thr;
	logic               nxt_have_cand;
	ptc_job_t           nxt;

	always_comb begin
		ld = $signed({1'b0, prev_chi2_q}) - $signed({1'b0, reference_chi2});
		rd = $signed({1'b0, point_chi2}) - $signed({1'b0, reference_chi2});
		thr = $signed({2'b00, delta_threshold});
		lower = !have_prev_q || (point_chi2 < min_chi2_q);
		capture = !lower && !have_cand_q && (ld <= thr) && (rd >= thr);
		nxt_have_cand = lower ? 1'b0 : (have_cand_q || capture);
		nxt.found = nxt_have_cand;
		nxt.ly = capture ? prev_yield_q : cand_ly_q;
		nxt.ry = capture ? point_yield : cand_ry_q;
		nxt.ld = capture ? ld : cand_ld_q;
		nxt.rd = capture ? rd : cand_rd_q;
		nxt.thr = delta_threshold;
	end

	assign job = nxt;
	assign job_push = in_fire && last_point;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			have_cand_q <= 1'b0;
		end else if (in_fire) begin
			have_prev_q <= !last_point;
			have_cand_q <= last_point ? 1'b0 : nxt_have_cand;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			prev_yield_q <= point_yield;
			prev_chi2_q <= point_chi2;
			if (lower) begin
				min_chi2_q <= point_chi2;
			end
			cand_ly_q <= nxt.ly;
			cand_ry_q <= nxt.ry;
			cand_ld_q <= nxt.ld;
			cand_rd_q <= nxt.rd;
		end
	end

endmodule
`default_nettype wire

>>> design/ptc_fifo.sv
// two-entry queue of finished scans between front and back
`timescale 1ns / 1ps
`default_nettype none
module ptc_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire ptc_pkg::ptc_job_t push_job,
	input  wire logic              pop,
	output ptc_pkg::ptc_job_t      head,
	output logic                   empty,
	output logic                   full
);
	import ptc_pkg::*;

	localparam int unsigned ENTRIES = 2 ** DEPTH_W;

	ptc_job_t             slot_q [ENTRIES];
	logic [DEPTH_W-1:0]   wr_ptr_q;
	logic [DEPTH_W-1:0]   rd_ptr_q;
	logic [DEPTH_W:0]     count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == (DEPTH_W+1)'(ENTRIES));
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule
`default_nettype wire

>>> design/ptc_back.sv
// back part: serial multiply-divide interpolation and output register
`timescale 1ns / 1ps
`default_nettype none
`include "profile_threshold_crossing_core_macros.svh"
module ptc_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ptc_pkg::ptc_job_t head,
	input  wire logic              empty,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   out_found,
	output logic signed [31:0]     out_yield
);
	import ptc_pkg::*;

	ptc_bk_state_t      state_q;
	ptc_bk_state_t      state_nxt;
	logic               load_out;

	logic [CNT_W-1:0]   cnt_q;
	logic [32:0]        num_q;
	logic [32:0]        den_q;
	logic [32:0]        mag_q;
	logic [32:0]        r_q;
	logic [32:0]        q_q;
	logic               neg_q;
	logic               found_q;
	logic signed [31:0] base_q;

	logic               out_valid_q;
	logic               out_found_q;
	logic signed [31:0] out_yield_q;

	logic signed [33:0] num_w;
	logic signed [33:0] den_w;
	logic signed [32:0] step_w;
	logic [32:0]        mag_w;
	logic [34:0]        t_w;
	logic [34:0]        t1_w;
	logic [34:0]        t2_w;
	logic [32:0]        r_nxt;
	logic [1:0]         k_w;
	logic [31:0]        res_w;

	// operands of the interpolation
	always_comb begin
		num_w = $signed({3'b000, head.thr}) - $signed({head.ld[32], head.ld});
		den_w = $signed({head.rd[32], head.rd}) - $signed({head.ld[32], head.ld});
		step_w = $signed({head.ry[31], head.ry}) - $signed({head.ly[31], head.ly});
		mag_w = step_w[32] ? 33'(-step_w) : 33'(step_w);
	end

	// one step: t = 2r + bit*num, then at most two subtracts of den
	always_comb begin
		t_w = {1'b0, r_q, 1'b0} + (mag_q[32] ? {2'b00, num_q} : 35'd0);
		t1_w = t_w - {2'b00, den_q};
		t2_w = t_w - {1'b0, den_q, 1'b0};
		priority if (t_w >= {1'b0, den_q, 1'b0}) begin
			k_w = 2'd2;
			r_nxt = t2_w[32:0];
		end else if (t_w >= {2'b00, den_q}) begin
			k_w = 2'd1;
			r_nxt = t1_w[32:0];
		end else begin
			k_w = 2'd0;
			r_nxt = t_w[32:0];
		end
		res_w = neg_q ? (32'(base_q) - q_q[31:0]) : (32'(base_q) + q_q[31:0]);
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!empty) begin
					state_nxt = (head.found && den_w != '0) ? BK_RUN : BK_DONE;
				end
			end
			BK_RUN: begin
				if (cnt_q == CNT_W'(1)) begin
					state_nxt = BK_DONE;
				end
			end
			BK_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_nxt = BK_IDLE;
				end
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE: pop = !empty;
			BK_RUN:  pop = 1'b0;
			BK_DONE: load_out = !out_valid_q || out_ready;
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			num_q <= num_w[32:0];
			den_q <= den_w[32:0];
			mag_q <= mag_w;
			neg_q <= head.found && den_w != '0 && step_w[32];
			found_q <= head.found;
			r_q <= '0;
			q_q <= '0;
			cnt_q <= CNT_W'(STEPS);
			// not found reports zero, flat denominator reports the right yield
			base_q <= !head.found ? 32'sd0 : ((den_w == '0) ? head.ry : head.ly);
		end else if (state_q == BK_RUN) begin
			mag_q <= {mag_q[31:0], 1'b0};
			r_q <= r_nxt;
			q_q <= {q_q[31:0], 1'b0} + {31'd0, k_w};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_found_q <= found_q;
			out_yield_q <= res_w;
		end
	end

	assign out_valid = out_valid_q;
	assign out_found = out_found_q;
	assign out_yield = out_yield_q;

	`PTC_ASSERT_IMPL(a_rem_below_den, clk, arst_n, state_q == BK_RUN, r_q < den_q)
	`PTC_ASSERT_NEXT(a_run_ends, clk, arst_n, state_q == BK_RUN && cnt_q == CNT_W'(1),
		state_q == BK_DONE)
	`PTC_ASSERT_IMPL(a_nf_zero, clk, arst_n, load_out && !found_q, res_w == '0)
	`PTC_ASSERT_IMPL(a_pop_idle, clk, arst_n, state_q != BK_IDLE, !pop)

endmodule
`default_nettype wire

>>> tb/tb.sv
// testbench for profile_threshold_crossing_core: scan points in, crossing yields checked
`timescale 1ns / 1ps
module tb;
	import ptc_pkg::*;

	localparam int POINTS_PER_PHASE = 172;
	localparam int NUM_DIRECTED = 25;
	localparam int NUM_PHASES = 7;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic        found;
		logic [31:0] yield;
	} crossing_t;

	typedef struct packed {
		logic [31:0] yield;
		logic [31:0] chi2;
		logic        last;
		logic        typed;
		logic        found;
		logic [31:0] want_yield;
	} point_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;   // point_yield [31:0], point_chi2 [63:32]
	logic        s_axis_tlast;   // last_point
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // crossing_yield [31:0]
	logic        m_axis_tuser;   // found [0]
	logic        cfg_wr_en;
	logic        cfg_index;
	logic [31:0] cfg_wdata;

	profile_threshold_crossing_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// register shadows
	logic [31:0] ref_level;
	logic [30:0] thr_level;

	// scan tracking state
	bit          scan_open;
	logic [31:0] prev_yield;
	logic [31:0] prev_chi2;
	logic [31:0] lowest_chi2;
	bit          pair_held;
	int          pair_ly;
	int          pair_ry;
	longint      pair_ld;
	longint      pair_rd;

	crossing_t pending_crossings[$];

	int  mismatches;
	int  points_sent;
	int  scans_sent;
	int  crossings_seen;
	int  misses_seen;
	int  settings_used;
	int  burst_left;
	bit  sender_active;

	point_row_t directed_rows [NUM_DIRECTED] = '{
		// lone point, nothing to cross
		'{32'h0001_0000, 32'h0000_1000, 1'b1, 1'b1, 1'b0, 32'h0},
		'{32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 32'h0},
		// exact half way between the two points
		'{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'h0001_0000, 32'h0005_6B86, 1'b1, 1'b1, 1'b1, 32'h0000_8000},
		// flat pair sitting on the threshold gives the right yield
		'{32'h0005_0000, 32'h0002_B5C3, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'h0007_0000, 32'h0002_B5C3, 1'b1, 1'b1, 1'b1, 32'h0007_0000},
		// stays below threshold
		'{32'h0000_0001, 32'h0000_0100, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0002, 32'h0000_0200, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0003, 32'h0000_0300, 1'b1, 1'b1, 1'b0, 32'h0},
		// crossing dropped by a later, lower minimum
		'{32'h0001_0000, 32'h0000_1000, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'h0002_0000, 32'h0010_0000, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'h0003_0000, 32'h0000_0800, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'h0004_0000, 32'h0000_0900, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'h0005_0000, 32'h0000_0A00, 1'b1, 1'b1, 1'b0, 32'h0},
		// equal chi2 keeps the first minimum
		'{32'h0001_0000, 32'h0000_1000, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'h0002_0000, 32'h0000_1000, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'h0003_0000, 32'h0010_0000, 1'b1, 1'b0, 1'b0, 32'h0},
		// second crossing must not replace the first
		'{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'h0001_0000, 32'h0004_0000, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'h0002_0000, 32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'h0003_0000, 32'h0008_0000, 1'b1, 1'b0, 1'b0, 32'h0},
		// full range yields and chi2
		'{32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0},
		'{32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0}
	};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("profile_threshold_crossing_core test failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on %s: got %h, expected %h", what, got, want);
		mismatches++;
	endtask

	function automatic logic [31:0] clamp_chi2(input longint v);
		if (v < 0)
			return 32'h0;
		if (v > longint'(32'hFFFF_FFFF))
			return 32'hFFFF_FFFF;
		return v[31:0];
	endfunction

	function automatic void clear_scan_state();
		scan_open = 1'b0;
		prev_yield = '0;
		prev_chi2 = '0;
		lowest_chi2 = '1;
		pair_held = 1'b0;
		pair_ly = 0;
		pair_ry = 0;
		pair_ld = 0;
		pair_rd = 0;
	endfunction

	// left yield plus threshold fraction of the yield step, truncated toward the left; a flat pair gives the right yield
	function automatic logic [31:0] interp_crossing();
		longint      num;
		longint      den;
		longint      rise;
		longint      mag;
		logic [127:0] prod;
		logic [127:0] quo;
		if (pair_rd == pair_ld)
			return pair_ry;
		num = longint'(thr_level) - pair_ld;
		den = pair_rd - pair_ld;
		rise = longint'(pair_ry) - longint'(pair_ly);
		mag = (rise < 0) ? -rise : rise;
		prod = 128'(unsigned'(num)) * 128'(unsigned'(mag));
		quo = prod / 128'(unsigned'(den));
		if (rise < 0)
			return pair_ly - quo[31:0];
		return pair_ly + quo[31:0];
	endfunction

	task automatic track_point(input logic [31:0] y, input logic [31:0] c, input bit last,
			output bit gives, output crossing_t res);
		longint left_d;
		longint right_d;
		gives = 1'b0;
		res = '0;
		if (!scan_open || c < lowest_chi2) begin
			lowest_chi2 = c;
			pair_held = 1'b0;
		end else if (!pair_held) begin
			left_d = longint'(prev_chi2) - longint'(ref_level);
			right_d = longint'(c) - longint'(ref_level);
			if (left_d <= longint'(thr_level) && right_d >= longint'(thr_level)) begin
				pair_held = 1'b1;
				pair_ly = prev_yield;
				pair_ry = y;
				pair_ld = left_d;
				pair_rd = right_d;
			end
		end
		scan_open = 1'b1;
		prev_yield = y;
		prev_chi2 = c;
		if (last) begin
			gives = 1'b1;
			res.found = pair_held;
			res.yield = pair_held ? interp_crossing() : 32'h0;
			clear_scan_state();
		end
	endtask

	task automatic drive_point(input logic [31:0] y, input logic [31:0] c, input bit last,
			input bit typed, input bit t_found, input logic [31:0] t_yield);
		crossing_t guess;
		bit        gives;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {c, y};
		s_axis_tlast <= last;
		sender_active = 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		track_point(y, c, last, gives, guess);
		if (gives) begin
			if (typed) begin
				guess.found = t_found;
				guess.yield = t_yield;
			end
			pending_crossings.insert(pending_crossings.size(), guess);
			scans_sent++;
		end
		points_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// gap with valid low between bursts so valid never drops and rises in one step
			s_axis_tvalid <= 1'b0;
			sender_active = 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic settle();
		if (sender_active) begin
			s_axis_tvalid <= 1'b0;
			sender_active = 1'b0;
		end
		while (pending_crossings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] ref_word, input logic [31:0] thr_word);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_REF;
		cfg_wdata <= ref_word;
		@(posedge clk);
		cfg_index <= CFG_THR;
		cfg_wdata <= thr_word;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		ref_level = ref_word;
		thr_level = thr_word[30:0];
		settings_used++;
	endtask

	task automatic random_scan();
		int          len;
		int          mid;
		int          mode;
		int          reach;
		longint      base;
		longint      curve;
		longint      chi;
		logic [31:0] y;
		logic [31:0] ystep;
		bit          wild;
		if ($urandom_range(0, 99) < 4)
			len = 1;
		else if ($urandom_range(0, 99) < 5)
			len = $urandom_range(60, 120);
		else
			len = $urandom_range(2, 30);
		mode = $urandom_range(0, 9);
		mid = $urandom_range(0, len - 1);
		base = longint'(ref_level) + longint'($urandom_range(0, thr_level / 2 + 64))
			- longint'($urandom_range(0, thr_level / 4 + 64));
		reach = $urandom_range(1, len);
		curve = longint'(thr_level) / longint'(reach * reach)
			+ longint'($urandom_range(1, 4096));
		y = $urandom;
		ystep = $urandom_range(0, 32'h0004_0000);
		if ($urandom_range(0, 1) == 1)
			ystep = -ystep;
		wild = (mode == 7) || ($urandom_range(0, 7) == 0);
		for (int i = 0; i < len; i++) begin
			case (mode)
				7: begin
					chi = longint'($urandom);
				end
				8: begin
					chi = longint'(ref_level) + longint'(thr_level)
						+ longint'($urandom_range(0, 64)) - 32;
				end
				9: begin
					chi = longint'(ref_level) + longint'(thr_level);
				end
				default: begin
					// bowl-shaped profile around the minimum, light noise on top
					chi = base + curve * longint'((i - mid) * (i - mid))
						+ longint'($urandom_range(0, 255));
				end
			endcase
			drive_point(wild ? $urandom : y, clamp_chi2(chi), i == len - 1,
				1'b0, 1'b0, 32'h0);
			y = y + ystep;
		end
	endtask

	// receiver: long open stretches mixed with short stalls
	initial begin
		int  rx_left;
		bit  rx_open;
		rx_left = 0;
		rx_open = 1'b1;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_left != 0) begin
				rx_left--;
			end else begin
				rx_open = ~rx_open;
				if (rx_open)
					rx_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(0, 47);
				else
					rx_left = $urandom_range(0, 11);
			end
			m_axis_tready <= rx_open;
		end
	end

	always @(posedge clk) begin
		crossing_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_crossings.size() == 0) begin
				report_mismatch("result with nothing pending", m_axis_tdata, 32'h0);
			end else begin
				want = pending_crossings.pop_front();
				if (m_axis_tuser !== want.found)
					report_mismatch("found", {31'b0, m_axis_tuser}, {31'b0, want.found});
				if (m_axis_tdata !== want.yield)
					report_mismatch("crossing_yield", m_axis_tdata, want.yield);
				if (want.found)
					crossings_seen++;
				else
					misses_seen++;
			end
		end
	end

	initial begin
		logic [31:0] phase_ref [NUM_PHASES];
		logic [31:0] phase_thr [NUM_PHASES];
		int          phase_start;
		phase_ref = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0};
		phase_thr = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0,
			32'd65536, 32'd251658, 32'h0};
		phase_ref[4] = $urandom;
		phase_ref[5] = $urandom_range(0, 32'h4000_0000);
		phase_ref[6] = $urandom;
		phase_thr[6] = $urandom;
		mismatches = 0;
		points_sent = 0;
		scans_sent = 0;
		crossings_seen = 0;
		misses_seen = 0;
		settings_used = 1;
		burst_left = 0;
		sender_active = 1'b0;
		ref_level = '0;
		thr_level = THR_RESET;
		clear_scan_state();
		arst_n = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tlast <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_REF;
		cfg_wdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			drive_point(directed_rows[i].yield, directed_rows[i].chi2, directed_rows[i].last,
				directed_rows[i].typed, directed_rows[i].found, directed_rows[i].want_yield);

		// random scans at reset register values, then at each further setting
		phase_start = points_sent;
		while (points_sent - phase_start < POINTS_PER_PHASE)
			random_scan();
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			set_config(phase_ref[p], phase_thr[p]);
			phase_start = points_sent;
			while (points_sent - phase_start < POINTS_PER_PHASE)
				random_scan();
		end
		settle();

		$display("sent %0d points in %0d scans across %0d register settings",
			points_sent, scans_sent, settings_used);
		$display("%0d scans reported a crossing, %0d reported none",
			crossings_seen, misses_seen);
		if (mismatches == 0)
			$display("profile_threshold_crossing_core test passed");
		else
			$display("profile_threshold_crossing_core test failed");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+design
design/ptc_pkg.sv
design/ptc_front.sv
design/ptc_fifo.sv
design/ptc_back.sv
design/profile_threshold_crossing_core.sv
tb/tb.sv
